### design/button_debounce_short_long_press_defines.svh
// Assertion macros shared by the button qualifier RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef BUTTON_DEBOUNCE_SHORT_LONG_PRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_SHORT_LONG_PRESS_DEFINES_SVH

`ifndef SYNTHESIS
`define BDSLP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("check failed");
`define BDSLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define BDSLP_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define BDSLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### design/bdslp_pkg.sv
// Shared types and constants for the button qualifier.
// No dependencies.
`default_nettype none

package bdslp_pkg;

    localparam int PinWidth   = 4;
    localparam int CmdWidth   = 2;
    localparam int IndexWidth = 2;
    localparam int TicksWidth = 16;
    localparam int AddrWidth  = 3;
    localparam int DataWidth  = 32;

    localparam logic [TicksWidth-1:0] LongPressTicksReset = 16'd100;
    localparam logic                  PressedLevelReset   = 1'b0;
    localparam logic                  ReleasedAtReset     = 1'b1;

    typedef enum logic [CmdWidth-1:0] {
        CmdTick      = 2'd0,
        CmdReadShort = 2'd1,
        CmdReadLong  = 2'd2,
        CmdNone      = 2'd3
    } t_cmd;

    typedef enum logic {
        RegLongPressTicks = 1'b0,
        RegPressedLevel   = 1'b1
    } t_reg_sel;

    typedef enum logic [1:0] {
        ShortIdle  = 2'd0,
        ShortArmed = 2'd1,
        ShortDone  = 2'd2
    } t_short_stage;

    typedef struct packed {
        logic tick;
        logic clr_short;
        logic clr_long;
    } t_lane_ctl;

    typedef struct packed {
        logic short_done;
        logic long_flag;
    } t_lane_status;

endpackage

`default_nettype wire

### design/bdslp_regs.sv
// APB configuration registers: hold time and pressed pin level.
// Depends on bdslp_pkg.
`default_nettype none

module bdslp_regs (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [bdslp_pkg::AddrWidth-1:0]      paddr,
    input  wire  [bdslp_pkg::DataWidth-1:0]      pwdata,
    output logic [bdslp_pkg::DataWidth-1:0]      prdata,
    output logic                                 pready,
    output logic [bdslp_pkg::TicksWidth-1:0]     o_long_press_ticks,
    output logic                                 o_pressed_level
);
    import bdslp_pkg::*;

    logic [TicksWidth-1:0] r_long_press_ticks;
    logic                  r_pressed_level;
    logic                  w_write;
    t_reg_sel              w_sel;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;
    assign w_sel   = t_reg_sel'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ticks <= LongPressTicksReset;
            r_pressed_level    <= PressedLevelReset;
        end else if (w_write) begin
            unique case (w_sel)
                RegLongPressTicks: r_long_press_ticks <= pwdata[TicksWidth-1:0];
                RegPressedLevel:   r_pressed_level    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_sel)
            RegLongPressTicks: prdata = {{(DataWidth-TicksWidth){1'b0}}, r_long_press_ticks};
            RegPressedLevel:   prdata = {{(DataWidth-1){1'b0}}, r_pressed_level};
            default:           prdata = '0;
        endcase
    end

    assign o_long_press_ticks = r_long_press_ticks;
    assign o_pressed_level    = r_pressed_level;

endmodule

`default_nettype wire

### design/bdslp_button.sv
// One button lane: three-sample debounce, short press stage, hold counter.
// Depends on bdslp_pkg and the assertion macro header.
`default_nettype none
`include "button_debounce_short_long_press_defines.svh"

module bdslp_button #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  bdslp_pkg::t_lane_ctl   i_ctl,
    input  wire                          i_now,
    input  wire                          i_pressed_level,
    input  wire  [COUNT_WIDTH-1:0]       i_load,
    output bdslp_pkg::t_lane_status      o_status
);
    import bdslp_pkg::*;

    logic             r_oldest, n_oldest;
    logic             r_middle, n_middle;
    logic             r_stable, n_stable;
    t_short_stage     r_stage,  n_stage;
    logic [COUNT_WIDTH-1:0] r_hold_count, n_hold_count;
    logic             r_long_flag, n_long_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest     <= ReleasedAtReset;
            r_middle     <= ReleasedAtReset;
            r_stable     <= ReleasedAtReset;
            r_stage      <= ShortIdle;
            r_hold_count <= '0;
            r_long_flag  <= 1'b0;
        end else begin
            r_oldest     <= n_oldest;
            r_middle     <= n_middle;
            r_stable     <= n_stable;
            r_stage      <= n_stage;
            r_hold_count <= n_hold_count;
            r_long_flag  <= n_long_flag;
        end
    end

    always_comb begin
        n_oldest     = r_oldest;
        n_middle     = r_middle;
        n_stable     = r_stable;
        n_stage      = r_stage;
        n_hold_count = r_hold_count;
        n_long_flag  = r_long_flag;
        if (i_ctl.tick) begin
            n_oldest = r_middle;
            n_middle = i_now;
            if (r_oldest == r_middle && r_middle == i_now) begin
                if (r_stable != i_now) begin
                    n_stable = i_now;
                    if (i_now == i_pressed_level) begin
                        n_stage      = ShortArmed;
                        n_hold_count = i_load;
                    end else begin
                        unique case (r_stage)
                            ShortArmed: n_stage = ShortDone;
                            default:    n_stage = r_stage;
                        endcase
                    end
                end else if (i_now == i_pressed_level && r_hold_count != '0) begin
                    n_hold_count = r_hold_count - COUNT_WIDTH'(1);
                    if (r_hold_count == COUNT_WIDTH'(1)) begin
                        n_long_flag = 1'b1;
                        n_stage     = ShortIdle;
                    end
                end
            end
        end
        if (i_ctl.clr_short && r_stage == ShortDone) begin
            n_stage = ShortIdle;
        end
        if (i_ctl.clr_long) begin
            n_long_flag = 1'b0;
        end
    end

    assign o_status.short_done = (r_stage == ShortDone);
    assign o_status.long_flag  = r_long_flag;

    `BDSLP_ASSERT_SAME(a_long_at_one, i_clk, i_rst_n, !r_long_flag && n_long_flag,
        r_hold_count == COUNT_WIDTH'(1))
    `BDSLP_ASSERT_NEXT(a_stable_on_tick, i_clk, i_rst_n, !i_ctl.tick, $stable(r_stable))
    `BDSLP_ASSERT_NEXT(a_count_on_tick, i_clk, i_rst_n, !i_ctl.tick, $stable(r_hold_count))

endmodule

`default_nettype wire

### design/button_debounce_short_long_press.sv
// Multi-button debounce with short and long press detection: one item per
// clock while the result side does not stall. Items are registered,
// processed in a single pass against the per-button state, and the hit
// result is registered; the input and result registers let a new item be
// taken every unstalled cycle. Depends on bdslp_pkg, bdslp_regs, bdslp_button.
`default_nettype none
`include "button_debounce_short_long_press_defines.svh"

module button_debounce_short_long_press #(
    parameter int BUTTONS     = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire  [bdslp_pkg::CmdWidth-1:0]       i_cmd,
    input  wire  [bdslp_pkg::PinWidth-1:0]       i_pin_levels,
    input  wire  [bdslp_pkg::IndexWidth-1:0]     i_button_index,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic                                 o_hit,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [bdslp_pkg::AddrWidth-1:0]      paddr,
    input  wire  [bdslp_pkg::DataWidth-1:0]      pwdata,
    output logic [bdslp_pkg::DataWidth-1:0]      prdata,
    output logic                                 pready
);
    import bdslp_pkg::*;

    logic                  r_in_valid;
    t_cmd                  r_cmd;
    logic [PinWidth-1:0]   r_pins;
    logic [IndexWidth-1:0] r_button_index;
    logic                  r_out_valid;
    logic                  r_hit;
    logic                  n_hit;
    logic                  w_advance;
    logic                  w_accept;

    logic [TicksWidth-1:0]  w_long_press_ticks;
    logic                   w_pressed_level;
    logic [COUNT_WIDTH-1:0] w_load;

    logic [BUTTONS-1:0]     w_sel;
    logic [BUTTONS-1:0]     w_short_done;
    logic [BUTTONS-1:0]     w_long_flag;
    logic                   w_is_tick;
    logic                   w_is_short;
    logic                   w_is_long;

    bdslp_regs u_regs (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .o_long_press_ticks (w_long_press_ticks),
        .o_pressed_level    (w_pressed_level)
    );

    generate
        if (COUNT_WIDTH > TicksWidth) begin : g_load_wide
            assign w_load = {{(COUNT_WIDTH-TicksWidth){1'b0}}, w_long_press_ticks};
        end else begin : g_load_narrow
            assign w_load = w_long_press_ticks[COUNT_WIDTH-1:0];
        end
    endgenerate

    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd          <= t_cmd'(i_cmd);
            r_pins         <= i_pin_levels;
            r_button_index <= i_button_index;
        end
    end

    always_comb begin
        w_is_tick  = 1'b0;
        w_is_short = 1'b0;
        w_is_long  = 1'b0;
        case (r_cmd)
            CmdTick:      w_is_tick  = 1'b1;
            CmdReadShort: w_is_short = 1'b1;
            CmdReadLong:  w_is_long  = 1'b1;
            default: ;
        endcase
    end

    generate
        for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
            t_lane_ctl    w_ctl;
            t_lane_status w_status;
            logic         w_now;

            if (b < PinWidth) begin : g_pin
                assign w_now    = r_pins[b];
                assign w_sel[b] = (r_button_index == IndexWidth'(b));
            end else begin : g_nopin
                assign w_now    = 1'b0;
                assign w_sel[b] = 1'b0;
            end

            assign w_ctl.tick      = w_advance && w_is_tick;
            assign w_ctl.clr_short = w_advance && w_is_short && w_sel[b];
            assign w_ctl.clr_long  = w_advance && w_is_long && w_sel[b];

            bdslp_button #(
                .COUNT_WIDTH (COUNT_WIDTH)
            ) u_button (
                .i_clk           (i_clk),
                .i_rst_n         (i_rst_n),
                .i_ctl           (w_ctl),
                .i_now           (w_now),
                .i_pressed_level (w_pressed_level),
                .i_load          (w_load),
                .o_status        (w_status)
            );

            assign w_short_done[b] = w_status.short_done;
            assign w_long_flag[b]  = w_status.long_flag;
        end
    endgenerate

    assign n_hit = (w_is_short && |(w_sel & w_short_done))
                || (w_is_long && |(w_sel & w_long_flag));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_hit <= n_hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;

    `BDSLP_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, o_in_stall,
        r_in_valid && $stable(r_cmd) && $stable(r_button_index))
    `BDSLP_ASSERT_NEXT(a_advance_fills, i_clk, i_rst_n, w_advance, r_out_valid)
    `BDSLP_ASSERT_NEXT(a_tick_no_hit, i_clk, i_rst_n, w_advance && w_is_tick, !r_hit)

endmodule

`default_nettype wire

### test/tb_button_debounce_short_long_press.sv
// Self-checking testbench for button_debounce_short_long_press: drives sample ticks and
// flag reads through the valid/stall ports, programs the APB registers between phases,
// and checks every hit against an in-bench predictor. Depends on bdslp_pkg and the RTL.
module tb_button_debounce_short_long_press;
    timeunit 1ns;
    timeprecision 1ps;

    import bdslp_pkg::*;

    localparam int NumButtons   = 4;
    localparam int PhaseItems   = 275;
    localparam int LongHoldOff  = 80;

    class press_flag_tracker;
        bit [TicksWidth-1:0] hold_ticks;
        bit                  pressed;
        bit [1:0]            prior [NumButtons];
        bit                  stable [NumButtons];
        t_short_stage        short_st [NumButtons];
        bit [TicksWidth-1:0] hold [NumButtons];
        bit                  long_f [NumButtons];
        bit                  expected_hits [$];
        int                  errors;

        function new();
            hold_ticks = LongPressTicksReset;
            pressed    = PressedLevelReset;
            errors     = 0;
            for (int b = 0; b < NumButtons; b++) begin
                prior[b]    = {2{ReleasedAtReset}};
                stable[b]   = ReleasedAtReset;
                short_st[b] = ShortIdle;
                hold[b]     = '0;
                long_f[b]   = 1'b0;
            end
        endfunction

        function void set_reg(t_reg_sel sel, logic [DataWidth-1:0] value);
            if (sel == RegLongPressTicks) begin
                hold_ticks = value[TicksWidth-1:0];
            end else begin
                pressed = value[0];
            end
        endfunction

        function void sample_pins(logic [PinWidth-1:0] pins);
            bit now, oldest, middle;
            for (int b = 0; b < NumButtons; b++) begin
                now       = pins[b];
                oldest    = prior[b][0];
                middle    = prior[b][1];
                prior[b]  = {now, middle};
                if (oldest == middle && middle == now) begin
                    if (stable[b] != now) begin
                        stable[b] = now;
                        if (now == pressed) begin
                            short_st[b] = ShortArmed;
                            hold[b]     = hold_ticks;
                        end else if (short_st[b] == ShortArmed) begin
                            short_st[b] = ShortDone;
                        end
                    end else if (now == pressed && hold[b] != 0) begin
                        hold[b] = hold[b] - TicksWidth'(1);
                        if (hold[b] == 0) begin
                            long_f[b]   = 1'b1;
                            short_st[b] = ShortIdle;
                        end
                    end
                end
            end
        endfunction

        function void note_transfer(t_cmd c, logic [PinWidth-1:0] pins,
                                    logic [IndexWidth-1:0] idx);
            bit hit;
            hit = 1'b0;
            case (c)
                CmdTick: begin
                    sample_pins(pins);
                end
                CmdReadShort: begin
                    if (idx < NumButtons && short_st[idx] == ShortDone) begin
                        short_st[idx] = ShortIdle;
                        hit = 1'b1;
                    end
                end
                CmdReadLong: begin
                    if (idx < NumButtons && long_f[idx]) begin
                        long_f[idx] = 1'b0;
                        hit = 1'b1;
                    end
                end
                default: ;
            endcase
            expected_hits.push_back(hit);
        endfunction

        function void check_hit(logic actual);
            bit exp_hit;
            if (expected_hits.size() == 0) begin
                $display("%0t: result with no transfer pending, hit %b", $time, actual);
                errors++;
            end else begin
                exp_hit = expected_hits.pop_front();
                if (actual !== exp_hit) begin
                    $display("%0t: hit mismatch, expected %b, actual %b",
                             $time, exp_hit, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic [CmdWidth-1:0]     cmd = CmdTick;
    logic [PinWidth-1:0]     pin_levels = '0;
    logic [IndexWidth-1:0]   button_index = '0;
    logic                    out_stall = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [AddrWidth-1:0]    paddr = '0;
    logic [DataWidth-1:0]    pwdata = '0;
    wire                     in_stall;
    wire                     out_valid;
    wire                     hit;
    wire  [DataWidth-1:0]    prdata;
    wire                     pready;

    press_flag_tracker tracker = new();
    int                src_mode = 0;
    int                sink_mode = 0;
    bit                hold_req = 1'b0;
    bit [PinWidth-1:0] intent = '1;

    button_debounce_short_long_press #(
        .BUTTONS    (NumButtons),
        .COUNT_WIDTH(TicksWidth)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_cmd         (cmd),
        .i_pin_levels  (pin_levels),
        .i_button_index(button_index),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_hit         (hit),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("button_debounce_short_long_press test failed");
        $finish;
    end

    function automatic int pick_gap(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0 || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    // result side: stall pattern plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_valid && !out_stall) begin
                tracker.check_hit(hit);
            end
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LongHoldOff;
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                stall_left = pick_gap(sink_mode);
            end
        end
    end

    task automatic write_reg(t_reg_sel sel, logic [DataWidth-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrWidth'(int'(sel) * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_reg(sel, value);
    endtask

    task automatic send_item(t_cmd c, logic [PinWidth-1:0] pins, logic [IndexWidth-1:0] idx);
        int gap;
        gap = pick_gap(src_mode);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid     <= 1'b1;
        cmd          <= c;
        pin_levels   <= pins;
        button_index <= idx;
        do @(posedge i_clk); while (in_stall);
        tracker.note_transfer(c, pins, idx);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(int ticks, bit level, int smode, int kmode, bit long_hold);
        int                  done;
        int                  r;
        t_cmd                c;
        logic [PinWidth-1:0] raw;
        write_reg(RegLongPressTicks, DataWidth'(ticks));
        write_reg(RegPressedLevel, DataWidth'(level));
        src_mode  = smode;
        sink_mode = kmode;
        hold_req  = long_hold;
        done      = 0;
        while (done < PhaseItems) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                for (int b = 0; b < PinWidth; b++) begin
                    if ($urandom_range(0, 11) == 0) intent[b] = ~intent[b];
                end
                raw = intent;
                for (int b = 0; b < PinWidth; b++) begin
                    if ($urandom_range(0, 19) == 0) raw[b] = ~raw[b];
                end
                c = CmdTick;
            end else begin
                raw = PinWidth'($urandom);
                c   = (r < 85) ? CmdReadShort : (r < 97) ? CmdReadLong : CmdNone;
            end
            send_item(c, raw, IndexWidth'($urandom));
            if (c != CmdNone) done++;
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: pressed is a low pin, long press after two held ticks
        write_reg(RegLongPressTicks, 32'd2);
        send_item(CmdReadShort, 4'h0, 2'd0);
        repeat (5) send_item(CmdTick, 4'h0, 2'd0);
        for (int b = 0; b < NumButtons; b++) send_item(CmdReadLong, 4'hF, IndexWidth'(b));
        send_item(CmdReadLong, 4'h0, 2'd3);
        repeat (3) send_item(CmdTick, 4'hF, 2'd1);
        repeat (3) send_item(CmdTick, 4'h0, 2'd2);
        repeat (3) send_item(CmdTick, 4'hF, 2'd3);
        for (int b = 0; b < NumButtons; b++) send_item(CmdReadShort, 4'h0, IndexWidth'(b));
        send_item(CmdNone, 4'h5, 2'd2);
        drain();

        run_phase(1, 1'b0, 0, 0, 1'b1);
        run_phase(0, 1'b1, 1, 1, 1'b0);
        run_phase(65535, 1'b0, 1, 0, 1'b0);
        run_phase($urandom_range(2, 12), 1'b1, 0, 1, 1'b0);
        run_phase($urandom_range(3, 20), 1'b0, 1, 1, 1'b0);
        run_phase($urandom_range(1, 8), 1'b1, 1, 1, 1'b0);

        if (tracker.errors == 0) begin
            $display("button_debounce_short_long_press test passed");
        end else begin
            $display("button_debounce_short_long_press test failed");
        end
        $finish;
    end
endmodule

### files.f
+incdir+design
design/bdslp_pkg.sv
design/bdslp_regs.sv
design/bdslp_button.sv
design/button_debounce_short_long_press.sv
test/tb_button_debounce_short_long_press.sv
